>>> src/gfbch_pkg.sv
// ----------------------------------------------------------------------------
// gfbch_pkg
// Shared widths, code constants and GF(32) arithmetic for the BCH checksum.
// ----------------------------------------------------------------------------
package gfbch_pkg;

    localparam int SYM_W     = 5;
    localparam int SHORT_LEN = 13;
    localparam int LONG_LEN  = 15;
    localparam int CNT_W     = $clog2(LONG_LEN + 1);

    localparam logic [SYM_W-1:0] GF_MOD = 5'd9;  // x^5 + x^3 + 1, low bits

    typedef logic [LONG_LEN-1:0][SYM_W-1:0] t_rem;

    // generator coefficients, highest degree first
    localparam logic [SYM_W-1:0] SHORT_GEN [SHORT_LEN] = '{
        5'd25, 5'd27, 5'd17, 5'd8, 5'd0, 5'd25, 5'd25, 5'd25, 5'd31, 5'd27,
        5'd24, 5'd16, 5'd16
    };
    localparam logic [SYM_W-1:0] LONG_GEN [LONG_LEN] = '{
        5'd15, 5'd10, 5'd25, 5'd26, 5'd9, 5'd25, 5'd21, 5'd6, 5'd23, 5'd21,
        5'd6, 5'd5, 5'd22, 5'd4, 5'd23
    };
    // target residues, most significant first
    localparam logic [SYM_W-1:0] SHORT_TGT [SHORT_LEN] = '{
        5'd16, 5'd25, 5'd24, 5'd3, 5'd25, 5'd11, 5'd16, 5'd23, 5'd29, 5'd3,
        5'd25, 5'd17, 5'd10
    };
    localparam logic [SYM_W-1:0] LONG_TGT [LONG_LEN] = '{
        5'd16, 5'd25, 5'd24, 5'd3, 5'd25, 5'd11, 5'd16, 5'd23, 5'd29, 5'd3,
        5'd25, 5'd17, 5'd10, 5'd25, 5'd6
    };

    localparam t_rem REM_INIT = {{((LONG_LEN - 1) * SYM_W){1'b0}}, SYM_W'(1)};

    // checksum symbols, most significant first, already XORed with the target
    typedef struct packed {
        t_rem sym;
        logic match;
        logic long_code;
    } t_snap;

    function automatic logic [SYM_W-1:0] gf_mul(input logic [SYM_W-1:0] a,
                                                input logic [SYM_W-1:0] b);
        logic [SYM_W-1:0] acc;
        logic [SYM_W-1:0] x;
        logic             carry;
        acc = '0;
        x   = a;
        for (int i = 0; i < SYM_W; i++) begin
            if (b[i]) begin
                acc = acc ^ x;
            end
            carry = x[SYM_W-1];
            x     = {x[SYM_W-2:0], 1'b0};
            if (carry) begin
                x = x ^ GF_MOD;
            end
        end
        return acc;
    endfunction

endpackage

>>> src/gfbch_in_if.sv
// ----------------------------------------------------------------------------
// gfbch_in_if
// Symbol input channel: valid/ready with symbol and framing flags.
// ----------------------------------------------------------------------------
interface gfbch_in_if;
    logic                        valid;
    logic                        ready;
    logic [gfbch_pkg::SYM_W-1:0] symbol;
    logic                        first;
    logic                        last;

    modport source (output valid, symbol, first, last, input ready);
    modport sink   (input valid, symbol, first, last, output ready);
endinterface

>>> src/gfbch_out_if.sv
// ----------------------------------------------------------------------------
// gfbch_out_if
// Checksum output channel: valid/ready with checksum symbol and flags.
// ----------------------------------------------------------------------------
interface gfbch_out_if;
    logic                        valid;
    logic                        ready;
    logic [gfbch_pkg::SYM_W-1:0] check_symbol;
    logic                        matches_target;
    logic                        end_of_run;

    modport source (output valid, check_symbol, matches_target, end_of_run,
                    input ready);
    modport sink   (input valid, check_symbol, matches_target, end_of_run,
                    output ready);
endinterface

>>> src/gfbch_rem.sv
// ----------------------------------------------------------------------------
// gfbch_rem
// Remainder register and one-symbol BCH update; builds the checksum snapshot.
// ----------------------------------------------------------------------------
module gfbch_rem (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_long_code,
    input  logic                        i_accept,
    input  logic [gfbch_pkg::SYM_W-1:0] i_symbol,
    input  logic                        i_first,
    input  logic                        i_last,
    output gfbch_pkg::t_snap            o_snap,
    output logic                        o_snap_we
);
    import gfbch_pkg::*;

    t_rem             r_rem;
    t_rem             n_rem;
    t_rem             cur;
    logic [SYM_W-1:0] top;

    always_comb begin
        cur = i_first ? REM_INIT : r_rem;
        if (!i_long_code) begin
            cur[LONG_LEN-1] = '0;
            cur[LONG_LEN-2] = '0;
        end
        top = i_long_code ? cur[LONG_LEN-1] : cur[SHORT_LEN-1];

        n_rem    = '0;
        n_rem[0] = i_symbol;
        for (int k = 1; k < LONG_LEN; k++) begin
            if (i_long_code || k < SHORT_LEN) begin
                n_rem[k] = cur[k-1];
            end
        end
        for (int k = 0; k < LONG_LEN; k++) begin
            if (i_long_code) begin
                n_rem[k] = n_rem[k] ^ gf_mul(LONG_GEN[LONG_LEN-1-k], top);
            end else if (k < SHORT_LEN) begin
                n_rem[k] = n_rem[k] ^ gf_mul(SHORT_GEN[SHORT_LEN-1-k], top);
            end
        end

        o_snap           = '0;
        o_snap.long_code = i_long_code;
        for (int j = 0; j < LONG_LEN; j++) begin
            if (i_long_code) begin
                o_snap.sym[j] = n_rem[LONG_LEN-1-j] ^ LONG_TGT[j];
            end else if (j < SHORT_LEN) begin
                o_snap.sym[j] = n_rem[SHORT_LEN-1-j] ^ SHORT_TGT[j];
            end
        end
        o_snap.match = (o_snap.sym == '0);
        o_snap_we    = i_accept && i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= REM_INIT;
        end else if (i_accept) begin
            r_rem <= n_rem;
        end
    end

endmodule

>>> src/gfbch_emit.sv
// ----------------------------------------------------------------------------
// gfbch_emit
// Pending snapshot slot and output shifter; sends one checksum symbol per
// transaction, most significant first.
// ----------------------------------------------------------------------------
module gfbch_emit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gfbch_pkg::t_snap i_snap,
    input  logic             i_snap_we,
    output logic             o_pend_full,
    gfbch_out_if.source      o_out
);
    import gfbch_pkg::*;

    t_snap            r_pend;
    logic             r_pend_valid;
    t_rem             r_sym;
    logic [CNT_W-1:0] r_cnt;
    logic             r_match;
    logic             out_hs;
    logic             load;

    assign o_out.valid          = (r_cnt != '0);
    assign o_out.check_symbol   = r_sym[0];
    assign o_out.matches_target = r_match;
    assign o_out.end_of_run     = (r_cnt == CNT_W'(1));
    assign o_pend_full          = r_pend_valid && (r_cnt != '0);

    assign out_hs = o_out.valid && o_out.ready;
    assign load   = r_pend_valid && ((r_cnt == '0) || (o_out.end_of_run && out_hs));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_snap_we) begin
            r_pend_valid <= 1'b1;
        end else if (load) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_snap_we) begin
            r_pend <= i_snap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (load) begin
            r_cnt <= r_pend.long_code ? CNT_W'(LONG_LEN) : CNT_W'(SHORT_LEN);
        end else if (out_hs) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_sym   <= r_pend.sym;
            r_match <= r_pend.match;
        end else if (out_hs) begin
            r_sym <= {{SYM_W{1'b0}}, r_sym[LONG_LEN-1:1]};
        end
    end

endmodule

>>> src/gf32_bch_checksum.sv
// ----------------------------------------------------------------------------
// gf32_bch_checksum
// BCH checksum over GF(32) with 13-symbol short and 15-symbol long codes.
//
//   channel   dir  handshake    payload
//   i_in      in   valid/ready  symbol[4:0], first, last
//   o_out     out  valid/ready  check_symbol[4:0], matches_target, end_of_run
//   i_cfg     in   write enable long_code
//
// One symbol per cycle enters the remainder update while input ready is high
// (combinational GF(32) XOR network). A last symbol parks its checksum in a
// one-entry slot, which loads the output shifter once the shifter is idle or
// its last symbol is taken; 13 or 15 symbols follow, one per cycle of ready.
// Input ready drops only while the slot holds a checksum behind a run that is
// still being sent.
// Reset is synchronous, active low, and restores the remainder to one.
// ----------------------------------------------------------------------------
module gf32_bch_checksum (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gfbch_in_if.sink    i_in,
    gfbch_out_if.source o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata
);
    import gfbch_pkg::*;

    logic  r_long_code;
    logic  accept;
    logic  pend_full;
    t_snap snap;
    logic  snap_we;

    assign i_in.ready = !pend_full;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_code <= 1'b0;
        end else if (i_cfg_we) begin
            r_long_code <= i_cfg_wdata;
        end
    end

    gfbch_rem u_rem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_long_code (r_long_code),
        .i_accept    (accept),
        .i_symbol    (i_in.symbol),
        .i_first     (i_in.first),
        .i_last      (i_in.last),
        .o_snap      (snap),
        .o_snap_we   (snap_we)
    );

    gfbch_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_snap      (snap),
        .i_snap_we   (snap_we),
        .o_pend_full (pend_full),
        .o_out       (o_out)
    );

endmodule
